>>> hdl/crgs_pkg.sv
package crgs_pkg;

  // Field widths
  localparam int COORD_W   = 11;
  localparam int COLOR_W   = 8;
  localparam int GRAY_W    = 8;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = SQ_W + 1;
  localparam int RSQ_W     = 23;
  localparam int SUM_W     = 30;
  localparam int COUNT_W   = 23;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = RSQ_W;

  // Raster extent; coordinates at or above it are off the raster
  localparam int MAX_DIMENSION = 2048;

  // Accumulator limits and reset values
  localparam logic [COUNT_W-1:0] COUNT_LIMIT    = 23'h7F_FFFF;
  localparam logic [SUM_W-1:0]   SUM_LIMIT      = 30'h3FFF_FFFF;
  localparam logic [GRAY_W-1:0]  GRAY_MIN_RESET = 8'hFF;
  localparam logic [GRAY_W-1:0]  GRAY_MAX_RESET = 8'h00;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 2'd2;

  // Queue between classifier and accumulator
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Mean divider: quotient bits and shifted divisor width
  localparam int QUOT_W   = GRAY_W;
  localparam int DEN_SH_W = COUNT_W + QUOT_W;
  localparam int STEP_W   = $clog2(QUOT_W + 1);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Classified pixel passed from front to back
  typedef struct packed {
    logic              in_roi;
    logic [GRAY_W-1:0] gray;
    logic              last;
  } item_t;

  // Frame totals handed to the divider
  typedef struct packed {
    logic [GRAY_W-1:0]  gray_min;
    logic [GRAY_W-1:0]  gray_max;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } stats_t;

  // Result item
  typedef struct packed {
    logic [GRAY_W-1:0]  gray_min;
    logic [GRAY_W-1:0]  gray_max;
    logic [GRAY_W-1:0]  gray_mean;
    logic [COUNT_W-1:0] pixel_count;
    logic               region_empty;
  } result_t;

  // Gray = (11r + 16g + 5b) / 32, truncated
  function automatic logic [GRAY_W-1:0] gray_of(input logic [COLOR_W-1:0] r,
                                                input logic [COLOR_W-1:0] g,
                                                input logic [COLOR_W-1:0] b);
    logic [COLOR_W+4:0] acc;
    acc = (COLOR_W+5)'(r) * (COLOR_W+5)'(11)
        + ((COLOR_W+5)'(g) << 4)
        + (COLOR_W+5)'(b) * (COLOR_W+5)'(5);
    return acc[COLOR_W+4:5];
  endfunction

endpackage

>>> hdl/circular_roi_gray_statistics.sv
// Pixels: one item per cycle while in_full is low; an accepted pixel is registered in
//   stage 1 and stage 2, queued, and folded into the totals once popped from the queue.
// Result: the mean divider goes straight to done for an empty region, else one bit a cycle.
// A frame-end item waits at the queue head until the divider is idle (prior result popped);
//   pixels behind it wait too; the input stalls when the queue is full and stage 2 is valid.
// Reset (rst_n low, synchronous): config and valids 0, queue empty, min 255, max/sum/count 0.
module circular_roi_gray_statistics (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crgs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [crgs_pkg::COORD_W-1:0]    in_pixel_x,
  input  logic [crgs_pkg::COORD_W-1:0]    in_pixel_y,
  input  logic [crgs_pkg::COLOR_W-1:0]    in_red,
  input  logic [crgs_pkg::COLOR_W-1:0]    in_green,
  input  logic [crgs_pkg::COLOR_W-1:0]    in_blue,
  input  logic                            in_frame_end,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [crgs_pkg::GRAY_W-1:0]     out_gray_min,
  output logic [crgs_pkg::GRAY_W-1:0]     out_gray_max,
  output logic [crgs_pkg::GRAY_W-1:0]     out_gray_mean,
  output logic [crgs_pkg::COUNT_W-1:0]    out_pixel_count,
  output logic                            out_region_empty
);

  crgs_pkg::item_t   front_item, back_item;
  crgs_pkg::stats_t  stats;
  crgs_pkg::result_t result;
  logic              item_push, fifo_full, fifo_empty, item_pop;
  logic              div_ready, div_start, div_empty;

  // Classify pixels
  crgs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_frame_end (in_frame_end),
    .fifo_full_i  (fifo_full),
    .item_push_o  (item_push),
    .item_o       (front_item)
  );

  // Decouple classifier and accumulator
  crgs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (item_push),
    .data_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (item_pop),
    .data_o  (back_item),
    .empty_o (fifo_empty)
  );

  // Accumulate frame totals
  crgs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_i      (back_item),
    .empty_i     (fifo_empty),
    .pop_o       (item_pop),
    .div_ready_i (div_ready),
    .start_o     (div_start),
    .stats_o     (stats)
  );

  // Compute mean and hold the result
  crgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (div_start),
    .stats_i  (stats),
    .ready_o  (div_ready),
    .result_o (result),
    .empty_o  (div_empty),
    .pop_i    (out_pop)
  );

  assign out_empty        = div_empty;
  assign out_gray_min     = result.gray_min;
  assign out_gray_max     = result.gray_max;
  assign out_gray_mean    = result.gray_mean;
  assign out_pixel_count  = result.pixel_count;
  assign out_region_empty = result.region_empty;

endmodule

>>> hdl/crgs_front.sv
module crgs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crgs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [crgs_pkg::COORD_W-1:0]        in_pixel_x,
  input  logic [crgs_pkg::COORD_W-1:0]        in_pixel_y,
  input  logic [crgs_pkg::COLOR_W-1:0]        in_red,
  input  logic [crgs_pkg::COLOR_W-1:0]        in_green,
  input  logic [crgs_pkg::COLOR_W-1:0]        in_blue,
  input  logic                                in_frame_end,
  input  logic                                fifo_full_i,
  output logic                                item_push_o,
  output crgs_pkg::item_t                     item_o
);

  logic [crgs_pkg::COORD_W-1:0] cx_r, cy_r;
  logic [crgs_pkg::RSQ_W-1:0]   rsq_r;

  logic                          v1_r, v2_r;
  logic [crgs_pkg::COORD_W-1:0]  dx_r, dy_r;
  logic [crgs_pkg::GRAY_W-1:0]   gray1_r, gray2_r;
  logic                          last1_r, last2_r, on1_r, on2_r;
  logic [crgs_pkg::SQ_W-1:0]     sqx_r, sqy_r;

  logic                          adv, accept;
  logic [crgs_pkg::COORD_W-1:0]  dx_nxt, dy_nxt;
  logic                          on_nxt;
  logic [crgs_pkg::DIST_W-1:0]   dist_sq;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rsq_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        crgs_pkg::CFG_CENTER_X:  cx_r  <= cfg_data[crgs_pkg::COORD_W-1:0];
        crgs_pkg::CFG_CENTER_Y:  cy_r  <= cfg_data[crgs_pkg::COORD_W-1:0];
        crgs_pkg::CFG_RADIUS_SQ: rsq_r <= cfg_data[crgs_pkg::RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the last stage is blocked by the queue
  assign adv     = !(v2_r && fifo_full_i);
  assign in_full = !adv;
  assign accept  = in_push && adv;

  // Distance terms and raster check for the incoming pixel
  always_comb begin
    dx_nxt = (in_pixel_x >= cx_r) ? in_pixel_x - cx_r : cx_r - in_pixel_x;
    dy_nxt = (in_pixel_y >= cy_r) ? in_pixel_y - cy_r : cy_r - in_pixel_y;
    on_nxt = (32'(in_pixel_x) < crgs_pkg::MAX_DIMENSION) &&
             (32'(in_pixel_y) < crgs_pkg::MAX_DIMENSION);
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  // Stage 1: gray and absolute offsets; stage 2: squares
  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      gray1_r <= crgs_pkg::gray_of(in_red, in_green, in_blue);
      last1_r <= in_frame_end;
      on1_r   <= on_nxt;
    end
    if (adv) begin
      sqx_r   <= crgs_pkg::SQ_W'(dx_r) * crgs_pkg::SQ_W'(dx_r);
      sqy_r   <= crgs_pkg::SQ_W'(dy_r) * crgs_pkg::SQ_W'(dy_r);
      gray2_r <= gray1_r;
      last2_r <= last1_r;
      on2_r   <= on1_r;
    end
  end

  // Classify against the circle and hand the item to the queue
  assign dist_sq     = crgs_pkg::DIST_W'(sqx_r) + crgs_pkg::DIST_W'(sqy_r);
  assign item_push_o = v2_r && adv;
  assign item_o.in_roi = on2_r && (dist_sq <= crgs_pkg::DIST_W'(rsq_r));
  assign item_o.gray   = gray2_r;
  assign item_o.last   = last2_r;

endmodule

>>> hdl/crgs_fifo.sv
module crgs_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  crgs_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output crgs_pkg::item_t data_o,
  output logic            empty_o
);

  crgs_pkg::item_t                 mem_r [crgs_pkg::FIFO_DEPTH];
  logic [crgs_pkg::FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [crgs_pkg::FIFO_AW:0]      count_r;

  assign full_o  = count_r == (crgs_pkg::FIFO_AW+1)'(crgs_pkg::FIFO_DEPTH);
  assign empty_o = count_r == '0;
  assign data_o  = mem_r[rd_ptr_r];

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_i)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("push into full queue");

  ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

>>> hdl/crgs_back.sv
module crgs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  crgs_pkg::item_t  item_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             div_ready_i,
  output logic             start_o,
  output crgs_pkg::stats_t stats_o
);

  logic [crgs_pkg::GRAY_W-1:0]  min_r, max_r;
  logic [crgs_pkg::SUM_W-1:0]   sum_r;
  logic [crgs_pkg::COUNT_W-1:0] count_r;

  logic                         take;
  logic [crgs_pkg::SUM_W:0]     sum_wide;

  // Hold a frame-end item until the divider is free
  assign pop_o   = !empty_i && (!item_i.last || div_ready_i);
  assign start_o = pop_o && item_i.last;
  assign take    = pop_o && item_i.in_roi && (count_r < crgs_pkg::COUNT_LIMIT);

  // Fold the popped pixel into the running totals
  always_comb begin
    stats_o  = '{gray_min: min_r, gray_max: max_r, sum: sum_r, count: count_r};
    sum_wide = (crgs_pkg::SUM_W+1)'(sum_r) + (crgs_pkg::SUM_W+1)'(item_i.gray);
    if (take) begin
      if (item_i.gray < min_r) stats_o.gray_min = item_i.gray;
      if (item_i.gray > max_r) stats_o.gray_max = item_i.gray;
      stats_o.sum   = (sum_wide > (crgs_pkg::SUM_W+1)'(crgs_pkg::SUM_LIMIT)) ?
                      crgs_pkg::SUM_LIMIT : sum_wide[crgs_pkg::SUM_W-1:0];
      stats_o.count = count_r + 1'b1;
    end
  end

  // Update accumulators; clear them once the frame is handed off
  always_ff @(posedge clk) begin
    if (!rst_n || start_o) begin
      min_r   <= crgs_pkg::GRAY_MIN_RESET;
      max_r   <= crgs_pkg::GRAY_MAX_RESET;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      min_r   <= stats_o.gray_min;
      max_r   <= stats_o.gray_max;
      sum_r   <= stats_o.sum;
      count_r <= stats_o.count;
    end
  end

  ap_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    start_o |=> (count_r == '0) && (sum_r == '0) &&
                (min_r == crgs_pkg::GRAY_MIN_RESET))
    else $error("accumulators not cleared after frame end");

endmodule

>>> hdl/crgs_div.sv
module crgs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  crgs_pkg::stats_t  stats_i,
  output logic              ready_o,
  output crgs_pkg::result_t result_o,
  output logic              empty_o,
  input  logic              pop_i
);

  crgs_pkg::div_state_t state_r, state_nxt;

  logic [crgs_pkg::SUM_W-1:0]    rem_r, rem_nxt;
  logic [crgs_pkg::DEN_SH_W-1:0] den_sh_r, den_sh_nxt;
  logic [crgs_pkg::QUOT_W-1:0]   quot_r, quot_nxt;
  logic [crgs_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [crgs_pkg::GRAY_W-1:0]   min_r, min_nxt, max_r, max_nxt;
  logic [crgs_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                          empty_r, empty_nxt;

  logic ge, clamp_step, stats_zero;

  assign ge         = crgs_pkg::DEN_SH_W'(rem_r) >= den_sh_r;
  assign clamp_step = step_r == crgs_pkg::STEP_W'(crgs_pkg::QUOT_W);
  assign stats_zero = stats_i.count == '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crgs_pkg::DIV_IDLE: begin
        if (start_i) state_nxt = stats_zero ? crgs_pkg::DIV_DONE : crgs_pkg::DIV_RUN;
      end
      crgs_pkg::DIV_RUN: begin
        if ((clamp_step && ge) || step_r == '0) state_nxt = crgs_pkg::DIV_DONE;
      end
      crgs_pkg::DIV_DONE: begin
        if (pop_i) state_nxt = crgs_pkg::DIV_IDLE;
      end
      default: state_nxt = crgs_pkg::DIV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ready_o = 1'b0;
    empty_o = 1'b1;
    case (state_r)
      crgs_pkg::DIV_IDLE: ready_o = 1'b1;
      crgs_pkg::DIV_RUN:  ;
      crgs_pkg::DIV_DONE: empty_o = 1'b0;
      default: ;
    endcase
  end

  // Datapath: load totals, then one restoring step per cycle, MSB first;
  // the first step clamps the mean when sum >= 256 * count
  always_comb begin
    rem_nxt    = rem_r;
    den_sh_nxt = den_sh_r;
    quot_nxt   = quot_r;
    step_nxt   = step_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    count_nxt  = count_r;
    empty_nxt  = empty_r;
    if (state_r == crgs_pkg::DIV_IDLE && start_i) begin
      rem_nxt    = stats_i.sum;
      den_sh_nxt = {stats_i.count, crgs_pkg::QUOT_W'(0)};
      quot_nxt   = '0;
      step_nxt   = crgs_pkg::STEP_W'(crgs_pkg::QUOT_W);
      min_nxt    = stats_zero ? '0 : stats_i.gray_min;
      max_nxt    = stats_zero ? '0 : stats_i.gray_max;
      count_nxt  = stats_i.count;
      empty_nxt  = stats_zero;
    end else if (state_r == crgs_pkg::DIV_RUN) begin
      if (clamp_step) begin
        if (ge) quot_nxt = '1;
      end else begin
        quot_nxt = {quot_r[crgs_pkg::QUOT_W-2:0], ge};
        if (ge) rem_nxt = rem_r - den_sh_r[crgs_pkg::SUM_W-1:0];
      end
      den_sh_nxt = den_sh_r >> 1;
      if (step_r != '0) step_nxt = step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crgs_pkg::DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    den_sh_r <= den_sh_nxt;
    quot_r   <= quot_nxt;
    step_r   <= step_nxt;
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    count_r  <= count_nxt;
    empty_r  <= empty_nxt;
  end

  assign result_o = '{gray_min: min_r, gray_max: max_r, gray_mean: quot_r,
                      pixel_count: count_r, region_empty: empty_r};

  ap_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> state_r == crgs_pkg::DIV_IDLE) else $error("start while busy");

  ap_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == crgs_pkg::DIV_DONE |-> (empty_r == (count_r == '0)))
    else $error("empty flag disagrees with count");

  ap_pop_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == crgs_pkg::DIV_DONE && pop_i) |=> state_r == crgs_pkg::DIV_IDLE)
    else $error("result not released after pop");

endmodule
